// ===== rtl/bicv_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and crc helpers of the boot image crc verifier
package bicv_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned RegW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [RegW-1:0] CrcPoly        = 32'hEDB8_8320;
  localparam logic [RegW-1:0] AllOnes        = 32'hFFFF_FFFF;
  localparam logic [RegW-1:0] SizeLimitReset = 32'd16777216;

  // register indexes of the config port
  localparam logic [CfgIdxW-1:0] RegHeaderMagic  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPayloadSize  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegExpectedCrc  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAcceptedMagic = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSizeLimit    = 3'd4;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_BAD_MAGIC = 3'd1,
    VERDICT_BAD_SIZE  = 3'd2,
    VERDICT_MISMATCH  = 3'd3,
    VERDICT_BUSY      = 3'd4
  } verdict_e;

  typedef struct packed {
    logic            check_done;
    verdict_e        verdict;
    logic [RegW-1:0] running_crc;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] idx;
    logic [RegW-1:0]    data;
  } cfg_wr_t;

  typedef logic [RegW-1:0] crc_table_t [256];

  function automatic crc_table_t build_crc_table();
    crc_table_t tab;
    logic [RegW-1:0] c;
    for (int i = 0; i < 256; i++) begin
      c = RegW'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      tab[i] = c;
    end
    return tab;
  endfunction

  localparam crc_table_t CrcTable = build_crc_table();

  // byte-wide reflected crc-32 update through the table
  function automatic logic [RegW-1:0] crc32_byte(logic [RegW-1:0] crc,
                                                 logic [ByteW-1:0] b);
    logic [ByteW-1:0] idx;
    idx = crc[ByteW-1:0] ^ b;
    return (crc >> ByteW) ^ CrcTable[idx];
  endfunction

endpackage

// ===== rtl/bicv_fifo.sv =====
`timescale 1ns / 1ps
// small flop-based queue used in front of and behind the check engine
module bicv_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/bicv_check.sv =====
`timescale 1ns / 1ps
// check engine: header checks, crc update, verdict and config registers
module bicv_check (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bicv_pkg::cfg_wr_t        cfg_i,
  input  logic                     in_empty_i,
  input  logic [bicv_pkg::ByteW-1:0] in_data_i,
  output logic                     in_pop_o,
  input  logic                     out_full_i,
  output logic                     out_push_o,
  output bicv_pkg::result_t        out_data_o
);
  import bicv_pkg::*;

  logic [RegW-1:0] header_magic_q, payload_size_q, expected_crc_q;
  logic [RegW-1:0] accepted_magic_q, size_limit_q;

  logic [RegW-1:0] crc_q, crc_d;
  logic [RegW-1:0] bytes_seen_q, bytes_seen_d;
  logic            finished_q, finished_d;
  verdict_e        verdict_q, verdict_d;

  logic            step;
  logic            restart;
  logic            first_byte;
  logic [RegW-1:0] crc_next;
  logic [RegW-1:0] seen_next;

  assign step       = !in_empty_i && !out_full_i;
  assign in_pop_o   = step;
  assign out_push_o = step;

  assign restart = cfg_i.we && (cfg_i.idx == RegHeaderMagic ||
                                cfg_i.idx == RegPayloadSize ||
                                cfg_i.idx == RegExpectedCrc ||
                                cfg_i.idx == RegAcceptedMagic ||
                                cfg_i.idx == RegSizeLimit);

  assign first_byte = (bytes_seen_q == '0);
  assign crc_next   = crc32_byte(crc_q, in_data_i);
  assign seen_next  = bytes_seen_q + 1'b1;

  always_comb begin
    crc_d        = crc_q;
    bytes_seen_d = bytes_seen_q;
    finished_d   = finished_q;
    verdict_d    = verdict_q;
    if (step && !finished_q) begin
      if (first_byte && (header_magic_q != accepted_magic_q)) begin
        finished_d = 1'b1;
        verdict_d  = VERDICT_BAD_MAGIC;
      end else if (first_byte && ((payload_size_q == '0) ||
                                  (payload_size_q > size_limit_q))) begin
        finished_d = 1'b1;
        verdict_d  = VERDICT_BAD_SIZE;
      end else begin
        crc_d        = crc_next;
        bytes_seen_d = seen_next;
        if (seen_next == payload_size_q) begin
          finished_d = 1'b1;
          verdict_d  = ((crc_next ^ AllOnes) == expected_crc_q) ? VERDICT_OK
                                                                : VERDICT_MISMATCH;
        end
      end
    end
  end

  // result of this beat reflects the updated state
  always_comb begin
    out_data_o.check_done  = finished_d;
    out_data_o.verdict     = verdict_d;
    out_data_o.running_crc = crc_d ^ AllOnes;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_magic_q   <= '0;
      payload_size_q   <= '0;
      expected_crc_q   <= '0;
      accepted_magic_q <= '0;
      size_limit_q     <= SizeLimitReset;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        RegHeaderMagic:   header_magic_q   <= cfg_i.data;
        RegPayloadSize:   payload_size_q   <= cfg_i.data;
        RegExpectedCrc:   expected_crc_q   <= cfg_i.data;
        RegAcceptedMagic: accepted_magic_q <= cfg_i.data;
        RegSizeLimit:     size_limit_q     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q        <= AllOnes;
      bytes_seen_q <= '0;
      finished_q   <= 1'b0;
      verdict_q    <= VERDICT_BUSY;
    end else if (restart) begin
      crc_q        <= AllOnes;
      bytes_seen_q <= '0;
      finished_q   <= 1'b0;
      verdict_q    <= VERDICT_BUSY;
    end else begin
      crc_q        <= crc_d;
      bytes_seen_q <= bytes_seen_d;
      finished_q   <= finished_d;
      verdict_q    <= verdict_d;
    end
  end

endmodule

// ===== rtl/boot_image_crc_verifier_top.sv =====
`timescale 1ns / 1ps
// a byte is registered in the input queue, and its result from the check engine in the result queue
// throughput: one byte per cycle while the result queue has room, set by the combinational table crc update
// input and result queues each hold FifoDepth beats, so either side may stall alone
// reset: queues empty, config registers at their defaults, crc all ones,
// verdict in progress; no clearing pass
module boot_image_crc_verifier_top #(
  parameter int unsigned FifoDepth = bicv_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [bicv_pkg::ByteW-1:0]   payload_byte_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         check_done_o,
  output logic [2:0]                   verdict_o,
  output logic [bicv_pkg::RegW-1:0]    running_crc_o,
  input  logic                         cfg_we_i,
  input  logic [bicv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bicv_pkg::RegW-1:0]    cfg_wdata_i
);
  import bicv_pkg::*;

  localparam int unsigned ResW = $bits(result_t);

  cfg_wr_t          cfg;
  logic             in_empty, in_pop;
  logic [ByteW-1:0] in_data;
  logic             out_full, out_push;
  result_t          out_data, res;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  bicv_fifo #(
    .Width (ByteW),
    .Depth (FifoDepth)
  ) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (payload_byte_i),
    .full_o  (full),
    .pop_i   (in_pop),
    .data_o  (in_data),
    .empty_o (in_empty)
  );

  bicv_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_empty_i (in_empty),
    .in_data_i  (in_data),
    .in_pop_o   (in_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_data_o (out_data)
  );

  bicv_fifo #(
    .Width (ResW),
    .Depth (FifoDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_data),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (res),
    .empty_o (empty)
  );

  assign check_done_o  = res.check_done;
  assign verdict_o     = res.verdict;
  assign running_crc_o = res.running_crc;

endmodule

// ===== test/bicv_checker.sv =====
`timescale 1ns / 1ps
// checker of the boot image crc verifier: predicts every result beat and compares it
module bicv_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         full_i,
  input  logic [bicv_pkg::ByteW-1:0]   payload_byte_i,
  input  logic                         pop_i,
  input  logic                         empty_i,
  input  logic                         check_done_i,
  input  logic [2:0]                   verdict_i,
  input  logic [bicv_pkg::RegW-1:0]    running_crc_i,
  input  logic                         cfg_we_i,
  input  logic [bicv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bicv_pkg::RegW-1:0]    cfg_wdata_i,
  output int unsigned                  pending_o,
  output int unsigned                  fail_count_o
);
  import bicv_pkg::*;

  localparam int unsigned PrintCap = 100;

  logic [RegW-1:0] hdr_magic;
  logic [RegW-1:0] hdr_size;
  logic [RegW-1:0] hdr_crc;
  logic [RegW-1:0] good_magic;
  logic [RegW-1:0] max_size;

  logic [RegW-1:0] crc_acc;
  logic [RegW-1:0] byte_count;
  logic            image_closed;
  verdict_e        image_verdict;

  result_t     verdict_fifo[$];
  int unsigned mismatches;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what);
    if (mismatches < PrintCap) $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic void restart_image();
    crc_acc       = AllOnes;
    byte_count    = '0;
    image_closed  = 1'b0;
    image_verdict = VERDICT_BUSY;
  endfunction

  // bit-serial reflected crc-32, one byte
  function automatic logic [RegW-1:0] crc_shift_byte(input logic [RegW-1:0] crc,
                                                     input logic [ByteW-1:0] b);
    logic [RegW-1:0] c;
    c = crc ^ {{(RegW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic result_t take_payload_byte(input logic [ByteW-1:0] b);
    result_t r;
    if (!image_closed) begin
      if (byte_count == '0 && hdr_magic != good_magic) begin
        image_closed  = 1'b1;
        image_verdict = VERDICT_BAD_MAGIC;
      end else if (byte_count == '0 && (hdr_size == '0 || hdr_size > max_size)) begin
        image_closed  = 1'b1;
        image_verdict = VERDICT_BAD_SIZE;
      end else begin
        crc_acc    = crc_shift_byte(crc_acc, b);
        byte_count = byte_count + 1'b1;
        if (byte_count == hdr_size) begin
          image_closed  = 1'b1;
          image_verdict = ((crc_acc ^ AllOnes) == hdr_crc) ? VERDICT_OK : VERDICT_MISMATCH;
        end
      end
    end
    r.check_done  = image_closed;
    r.verdict     = image_verdict;
    r.running_crc = crc_acc ^ AllOnes;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    logic    reg_hit;
    if (!rst_ni) begin
      hdr_magic  = '0;
      hdr_size   = '0;
      hdr_crc    = '0;
      good_magic = '0;
      max_size   = SizeLimitReset;
      restart_image();
      verdict_fifo.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        reg_hit = 1'b1;
        case (cfg_idx_i)
          RegHeaderMagic:   hdr_magic  = cfg_wdata_i;
          RegPayloadSize:   hdr_size   = cfg_wdata_i;
          RegExpectedCrc:   hdr_crc    = cfg_wdata_i;
          RegAcceptedMagic: good_magic = cfg_wdata_i;
          RegSizeLimit:     max_size   = cfg_wdata_i;
          default:          reg_hit    = 1'b0;
        endcase
        // writes past the register list leave the check running
        if (reg_hit) restart_image();
      end
      if (push_i && !full_i) verdict_fifo.push_back(take_payload_byte(payload_byte_i));
      if (pop_i && !empty_i) begin
        if (verdict_fifo.size() == 0) begin
          report_mismatch("result beat with no byte waiting for it");
        end else begin
          want = verdict_fifo.pop_front();
          if (check_done_i !== want.check_done)
            report_mismatch($sformatf("check_done %b, predicted %b",
                                      check_done_i, want.check_done));
          if (verdict_i !== 3'(want.verdict))
            report_mismatch($sformatf("verdict %0d, predicted %0d",
                                      verdict_i, want.verdict));
          if (running_crc_i !== want.running_crc)
            report_mismatch($sformatf("running_crc %h, predicted %h",
                                      running_crc_i, want.running_crc));
        end
      end
      pending_o <= verdict_fifo.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// top of the boot image crc verifier test: clock, reset, byte and config stimulus, verdict
module testbench;
  import bicv_pkg::*;

  typedef logic [ByteW-1:0] byte_q_t[$];

  localparam int unsigned ImageItems = 1500;
  localparam int unsigned RegCount   = 5;
  localparam logic [CfgIdxW-1:0] RegBeyondList = 3'd7;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                push         = 1'b0;
  logic                pop          = 1'b0;
  logic [ByteW-1:0]    payload_byte = '0;
  logic                cfg_we       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx      = '0;
  logic [RegW-1:0]     cfg_wdata    = '0;
  logic                full;
  logic                empty;
  logic                check_done;
  logic [2:0]          verdict;
  logic [RegW-1:0]     running_crc;
  int unsigned         results_owed;
  int unsigned         mismatch_total;

  logic [RegW-1:0] hdr [RegCount];
  bit              push_calm;
  int unsigned     counted;

  always #10 clk = ~clk;

  boot_image_crc_verifier_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .payload_byte_i (payload_byte),
    .empty          (empty),
    .pop            (pop),
    .check_done_o   (check_done),
    .verdict_o      (verdict),
    .running_crc_o  (running_crc),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  bicv_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push_i         (push),
    .full_i         (full),
    .payload_byte_i (payload_byte),
    .pop_i          (pop),
    .empty_i        (empty),
    .check_done_i   (check_done),
    .verdict_i      (verdict),
    .running_crc_i  (running_crc),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .pending_o      (results_owed),
    .fail_count_o   (mismatch_total)
  );

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned idle_len(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [RegW-1:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return AllOnes;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [RegW-1:0] image_crc(input byte_q_t q);
    logic [RegW-1:0] c;
    c = AllOnes;
    foreach (q[i]) c = crc32_byte(c, q[i]);
    return c ^ AllOnes;
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = idle_len(push_calm);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    payload_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_slice(input byte_q_t q, input int first, input int last);
    for (int i = first; i <= last; i++) send_byte(q[i]);
  endtask

  // hold the byte side until every result beat has been taken
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_header(input logic [RegW-1:0] magic, input logic [RegW-1:0] size,
                             input logic [RegW-1:0] crc, input logic [RegW-1:0] accept,
                             input logic [RegW-1:0] limit);
    drain();
    hdr[RegHeaderMagic]   = magic;
    hdr[RegPayloadSize]   = size;
    hdr[RegExpectedCrc]   = crc;
    hdr[RegAcceptedMagic] = accept;
    hdr[RegSizeLimit]     = limit;
    for (int i = 0; i < RegCount; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CfgIdxW'(i);
      cfg_wdata <= hdr[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : result_side
    int unsigned gap;
    bit          calm;
    @(posedge rst_n);
    forever begin
      calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 12)) begin
        gap = idle_len(calm);
        if (gap != 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    byte_q_t          img;
    logic [RegW-1:0]  good_crc;
    logic [RegW-1:0]  magic;
    logic [RegW-1:0]  accept;
    logic [RegW-1:0]  size;
    logic [RegW-1:0]  limit;
    logic [RegW-1:0]  crc;
    int unsigned      kind;
    int unsigned      cut;
    int unsigned      ridx;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: size zero fails the size check, the second byte is ignored
    send_byte(8'h00);
    send_byte(8'hFF);
    // wrong magic and zero size together: magic is checked first
    load_header(AllOnes, '0, '0, '0, 32'd1);
    send_byte(8'hA5);
    send_byte(8'h5A);
    // size limit of zero
    load_header(32'h1234_5678, 32'd1, '0, 32'h1234_5678, '0);
    send_byte(8'h01);
    // size one above the limit
    load_header('0, AllOnes, '0, '0, 32'hFFFF_FFFE);
    send_byte(8'h80);
    // check string, size equal to limit, a write past the list in the middle
    img.delete();
    for (int i = 0; i < 9; i++) img.push_back(8'h31 + ByteW'(i));
    load_header(AllOnes, 32'd9, 32'hCBF4_3926, AllOnes, 32'd9);
    send_slice(img, 0, 3);
    drain();
    write_reg(RegBeyondList, AllOnes);
    send_slice(img, 4, 8);
    send_byte(8'h00);
    // a valid write in the middle restarts the image
    load_header(32'hDEAD_BEEF, 32'd3, '0, 32'hDEAD_BEEF, AllOnes);
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();
    write_reg(RegExpectedCrc, '0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h55);
    // single byte image with the right crc
    img.delete();
    img.push_back(8'hFF);
    load_header('0, 32'd1, image_crc(img), '0, 32'd1);
    send_byte(8'hFF);

    counted = 0;
    while (counted < ImageItems) begin
      push_calm = ($urandom_range(0, 3) == 0);
      kind      = $urandom_range(0, 99);
      accept    = pick_word();
      magic     = accept;
      if (kind < 70) begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        case ($urandom_range(0, 3))
          0:       limit = size;
          1:       limit = AllOnes;
          2:       limit = SizeLimitReset;
          default: limit = $urandom_range(size, size + 500);
        endcase
        img.delete();
        for (int i = 0; i < size; i++) img.push_back(ByteW'($urandom()));
        good_crc = image_crc(img);
        case ($urandom_range(0, 4))
          0:       crc = good_crc ^ (32'd1 << $urandom_range(0, 31));
          1:       crc = $urandom();
          default: crc = good_crc;
        endcase
        load_header(magic, size, crc, accept, limit);
        if (size >= 2 && $urandom_range(0, 9) == 0) begin
          cut = $urandom_range(1, size - 1);
          send_slice(img, 0, cut - 1);
          drain();
          if ($urandom_range(0, 1) == 0) begin
            write_reg(CfgIdxW'($urandom_range(RegCount, RegBeyondList)), $urandom());
            send_slice(img, cut, size - 1);
          end else begin
            ridx = $urandom_range(0, RegCount - 1);
            write_reg(CfgIdxW'(ridx), hdr[ridx]);
            send_slice(img, 0, size - 1);
            counted += cut;
          end
        end else begin
          send_slice(img, 0, size - 1);
        end
        counted += size;
        repeat ($urandom_range(0, 2)) send_byte(ByteW'($urandom()));
      end else begin
        if (kind < 85) begin
          magic = ($urandom_range(0, 1) == 0) ? (accept ^ (32'd1 << $urandom_range(0, 31)))
                                              : ~accept;
          size  = pick_word();
          limit = pick_word();
        end else begin
          limit = pick_word();
          if (limit == AllOnes || $urandom_range(0, 2) == 0) size = '0;
          else size = $urandom_range(limit + 1, AllOnes);
        end
        load_header(magic, size, pick_word(), accept, limit);
        repeat ($urandom_range(1, 3)) send_byte(ByteW'($urandom()));
        counted += 1;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_total == 0 && results_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== boot_image_crc_verifier_top.f =====
rtl/bicv_pkg.sv
rtl/bicv_fifo.sv
rtl/bicv_check.sv
rtl/boot_image_crc_verifier_top.sv
test/bicv_checker.sv
test/testbench.sv
